// ===== hw/rtl/bpc_pkg.sv =====
// Shared types, constants and helpers for the pressure compensation unit
`default_nettype none
package bpc_pkg;

   typedef struct packed {
      logic [19:0] raw_temp;
      logic [19:0] raw_press;
   } req_word_type;

   typedef struct packed {
      logic signed [14:0] temp_centi_c;
      logic [31:0]        station_press;
      logic [31:0]        sea_press;
      logic               div_zero;
   } rsp_word_type;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 64;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TEMP_TRIM  = 3'd0,
      CSR_PRESS_LOW  = 3'd1,
      CSR_PRESS_HIGH = 3'd2,
      CSR_PRESS_LAST = 3'd3,
      CSR_SEA_FACTOR = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [47:0] temp_trim;
      logic [63:0] press_low;
      logic [63:0] press_high;
      logic [15:0] press_last;
      logic [17:0] sea_factor;
   } trim_type;

   localparam logic [17:0]        SeaFactorReset = 18'd67529;
   localparam logic signed [63:0] TempMin        = -64'sd4000;
   localparam logic signed [63:0] TempMax        = 64'sd8500;
   localparam logic [63:0]        FineOffset     = 64'd128000;
   localparam logic [63:0]        PressBias      = 64'h0000_8000_0000_0000;
   localparam logic [63:0]        RawFull        = 64'd1048576;
   localparam logic [63:0]        DivScale       = 64'd3125;

   typedef enum logic [4:0] {
      BK_IDLE, BK_TA, BK_BB, BK_B3, BK_TC, BK_V1SQ, BK_V2A, BK_V2B, BK_V1A,
      BK_V1B, BK_V1C, BK_CHK, BK_NUM, BK_DIV, BK_PSQ, BK_P9, BK_P8, BK_FIN,
      BK_SEA, BK_DONE
   } back_state_type;

   typedef enum logic [2:0] {
      MUL_IDLE, MUL_LL, MUL_LH, MUL_HL, MUL_DONE
   } mul_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE, DIV_RUN, DIV_DONE
   } div_state_type;

   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bpc_front.sv =====
// Front end: two-word input queue
`default_nettype none
module bpc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire bpc_pkg::req_word_type req_word,
   output logic                       in_valid,
   output bpc_pkg::req_word_type      in_word,
   input  wire logic                  in_take
);
   import bpc_pkg::*;

   req_word_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign in_valid = (count_ff != 2'd0);
   assign in_word  = slot_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = in_take & in_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_mul.sv =====
// Wrapping 64x64 multiply, low half, on one 32x32 multiplier
`default_nettype none
module bpc_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [63:0]      result
);
   import bpc_pkg::*;

   mul_state_type state_ff, state_in;
   logic [63:0]   a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [31:0]   x, y;
   logic [63:0]   prod;

   assign prod   = x * y;
   assign result = acc_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MUL_IDLE: if (start) state_in = MUL_LL;
         MUL_LL:   state_in = MUL_LH;
         MUL_LH:   state_in = MUL_HL;
         MUL_HL:   state_in = MUL_DONE;
         MUL_DONE: state_in = MUL_IDLE;
         default:  state_in = MUL_IDLE;
      endcase
   end

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      acc_in = acc_ff;
      done   = 1'b0;
      x      = a_ff[31:0];
      y      = b_ff[31:0];
      unique case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               a_in = a;
               b_in = b;
            end
         end
         MUL_LL: acc_in = prod;
         MUL_LH: begin
            y      = b_ff[63:32];
            acc_in = acc_ff + {prod[31:0], 32'd0};
         end
         MUL_HL: begin
            x      = a_ff[63:32];
            acc_in = acc_ff + {prod[31:0], 32'd0};
         end
         MUL_DONE: done = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_div.sv =====
// Signed 64-bit truncating divider, one quotient bit per cycle
`default_nettype none
module bpc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             done,
   output logic [63:0]      quot
);
   import bpc_pkg::*;

   div_state_type state_ff, state_in;
   logic [63:0]   q_ff, q_in, rem_ff, rem_in, mb_ff, mb_in;
   logic          neg_ff, neg_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [63:0]   rsh;

   assign rsh  = {rem_ff[62:0], q_ff[63]};
   assign quot = neg_ff ? (64'd0 - q_ff) : q_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DIV_IDLE: if (start) state_in = DIV_RUN;
         DIV_RUN:  if (cnt_ff == 6'd63) state_in = DIV_DONE;
         DIV_DONE: state_in = DIV_IDLE;
         default:  state_in = DIV_IDLE;
      endcase
   end

   always_comb begin
      q_in   = q_ff;
      rem_in = rem_ff;
      mb_in  = mb_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      done   = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               q_in   = num[63] ? (64'd0 - num) : num;
               mb_in  = den[63] ? (64'd0 - den) : den;
               neg_in = num[63] ^ den[63];
               rem_in = 64'd0;
               cnt_in = 6'd0;
            end
         end
         DIV_RUN: begin
            cnt_in = cnt_ff + 6'd1;
            if (rsh >= mb_ff) begin
               rem_in = rsh - mb_ff;
               q_in   = {q_ff[62:0], 1'b1};
            end else begin
               rem_in = rsh;
               q_in   = {q_ff[62:0], 1'b0};
            end
         end
         DIV_DONE: done = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_back.sv =====
// Back end: compensation sequencer and result register
`default_nettype none
module bpc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire bpc_pkg::req_word_type in_word,
   output logic                       in_take,
   input  wire bpc_pkg::trim_type     trims,
   output logic                       empty,
   input  wire logic                  pop,
   output bpc_pkg::rsp_word_type      rsp_word
);
   import bpc_pkg::*;

   back_state_type     state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [19:0]        adc_t_ff, adc_t_in, adc_p_ff, adc_p_in;
   logic [63:0]        ra_ff, ra_in, v1_ff, v1_in, v2_ff, v2_in;
   logic [63:0]        sq_ff, sq_in, p_ff, p_in;
   logic [31:0]        tfine_ff, tfine_in, station_ff, station_in, sea_ff, sea_in;
   logic signed [14:0] temp_ff, temp_in;
   logic               dz_ff, dz_in;
   rsp_word_type       out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic               mul_start, mul_done, div_start, div_done, use_mul;
   logic [63:0]        mul_a, mul_b, mul_res, div_quot;
   logic [63:0]        t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [63:0]        tmp, tf64, tc, pf, s13;
   logic               can_out;

   assign t1 = {48'd0, trims.temp_trim[15:0]};
   assign t2 = sext16(trims.temp_trim[31:16]);
   assign t3 = sext16(trims.temp_trim[47:32]);
   assign p1 = {48'd0, trims.press_low[15:0]};
   assign p2 = sext16(trims.press_low[31:16]);
   assign p3 = sext16(trims.press_low[47:32]);
   assign p4 = sext16(trims.press_low[63:48]);
   assign p5 = sext16(trims.press_high[15:0]);
   assign p6 = sext16(trims.press_high[31:16]);
   assign p7 = sext16(trims.press_high[47:32]);
   assign p8 = sext16(trims.press_high[63:48]);
   assign p9 = sext16(trims.press_last);

   assign empty    = ~out_valid_ff;
   assign rsp_word = out_ff;
   assign can_out  = ~out_valid_ff | pop;

   bpc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   bpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (ra_ff),
      .den   (v1_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (in_valid) state_in = BK_TA;
         BK_TA:   if (mul_done) state_in = BK_BB;
         BK_BB:   if (mul_done) state_in = BK_B3;
         BK_B3:   if (mul_done) state_in = BK_TC;
         BK_TC:   state_in = BK_V1SQ;
         BK_V1SQ: if (mul_done) state_in = BK_V2A;
         BK_V2A:  if (mul_done) state_in = BK_V2B;
         BK_V2B:  if (mul_done) state_in = BK_V1A;
         BK_V1A:  if (mul_done) state_in = BK_V1B;
         BK_V1B:  if (mul_done) state_in = BK_V1C;
         BK_V1C:  if (mul_done) state_in = BK_CHK;
         BK_CHK:  state_in = (v1_ff == 64'd0) ? BK_DONE : BK_NUM;
         BK_NUM:  if (mul_done) state_in = BK_DIV;
         BK_DIV:  if (div_done) state_in = BK_PSQ;
         BK_PSQ:  if (mul_done) state_in = BK_P9;
         BK_P9:   if (mul_done) state_in = BK_P8;
         BK_P8:   if (mul_done) state_in = BK_FIN;
         BK_FIN:  state_in = BK_SEA;
         BK_SEA:  if (mul_done) state_in = BK_DONE;
         BK_DONE: if (can_out) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      issued_in    = issued_ff;
      adc_t_in     = adc_t_ff;
      adc_p_in     = adc_p_ff;
      ra_in        = ra_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      sq_in        = sq_ff;
      p_in         = p_ff;
      tfine_in     = tfine_ff;
      station_in   = station_ff;
      sea_in       = sea_ff;
      temp_in      = temp_ff;
      dz_in        = dz_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff & ~pop;
      in_take      = 1'b0;
      use_mul      = 1'b0;
      mul_a        = v1_ff;
      mul_b        = v1_ff;
      div_start    = 1'b0;
      tmp          = 64'd0;
      tf64         = sext32(tfine_ff);
      tc           = 64'($signed((tf64 << 2) + tf64 + 64'd128) >>> 8);
      pf           = 64'($signed(p_ff + ra_ff + v2_ff) >>> 8) + (p7 << 4);
      s13          = 64'($signed(p_ff) >>> 13);
      unique case (state_ff)
         BK_IDLE: begin
            in_take  = in_valid;
            adc_t_in = in_word.raw_temp;
            adc_p_in = in_word.raw_press;
         end
         BK_TA: begin
            use_mul = 1'b1;
            mul_a   = {47'd0, adc_t_ff[19:3]} - {47'd0, t1[15:0], 1'b0};
            mul_b   = t2;
            if (mul_done) ra_in = 64'($signed(mul_res) >>> 11);
         end
         BK_BB: begin
            use_mul = 1'b1;
            mul_a   = {48'd0, adc_t_ff[19:4]} - t1;
            mul_b   = mul_a;
            if (mul_done) sq_in = 64'($signed(mul_res) >>> 12);
         end
         BK_B3: begin
            use_mul = 1'b1;
            mul_a   = sq_ff;
            mul_b   = t3;
            tmp     = 64'($signed(mul_res) >>> 14);
            if (mul_done) tfine_in = ra_ff[31:0] + tmp[31:0];
         end
         BK_TC: begin
            if ($signed(tc) < TempMin) begin
               temp_in = 15'(TempMin);
            end else if ($signed(tc) > TempMax) begin
               temp_in = 15'(TempMax);
            end else begin
               temp_in = tc[14:0];
            end
            v1_in = tf64 - FineOffset;
         end
         BK_V1SQ: begin
            use_mul = 1'b1;
            if (mul_done) sq_in = mul_res;
         end
         BK_V2A: begin
            use_mul = 1'b1;
            mul_a   = sq_ff;
            mul_b   = p6;
            if (mul_done) v2_in = mul_res;
         end
         BK_V2B: begin
            use_mul = 1'b1;
            mul_b   = p5;
            if (mul_done) v2_in = v2_ff + (mul_res << 17) + (p4 << 35);
         end
         BK_V1A: begin
            use_mul = 1'b1;
            mul_a   = sq_ff;
            mul_b   = p3;
            if (mul_done) ra_in = 64'($signed(mul_res) >>> 8);
         end
         BK_V1B: begin
            use_mul = 1'b1;
            mul_b   = p2;
            if (mul_done) v1_in = PressBias + ra_ff + (mul_res << 12);
         end
         BK_V1C: begin
            use_mul = 1'b1;
            mul_b   = p1;
            if (mul_done) v1_in = 64'($signed(mul_res) >>> 33);
         end
         BK_CHK: begin
            if (v1_ff == 64'd0) begin
               dz_in      = 1'b1;
               station_in = 32'd0;
               sea_in     = 32'd0;
            end else begin
               dz_in = 1'b0;
               ra_in = ((RawFull - {44'd0, adc_p_ff}) << 31) - v2_ff;
            end
         end
         BK_NUM: begin
            use_mul = 1'b1;
            mul_a   = ra_ff;
            mul_b   = DivScale;
            if (mul_done) ra_in = mul_res;
         end
         BK_DIV: begin
            div_start = ~issued_ff;
            issued_in = ~div_done;
            if (div_done) p_in = div_quot;
         end
         BK_PSQ: begin
            use_mul = 1'b1;
            mul_a   = s13;
            mul_b   = s13;
            if (mul_done) sq_in = mul_res;
         end
         BK_P9: begin
            use_mul = 1'b1;
            mul_a   = sq_ff;
            mul_b   = p9;
            if (mul_done) ra_in = 64'($signed(mul_res) >>> 25);
         end
         BK_P8: begin
            use_mul = 1'b1;
            mul_a   = p_ff;
            mul_b   = p8;
            if (mul_done) v2_in = 64'($signed(mul_res) >>> 19);
         end
         BK_FIN: begin
            if (pf[63]) begin
               station_in = 32'd0;
            end else if (pf[63:32] != 32'd0) begin
               station_in = 32'hFFFF_FFFF;
            end else begin
               station_in = pf[31:0];
            end
         end
         BK_SEA: begin
            use_mul = 1'b1;
            mul_a   = {32'd0, station_ff};
            mul_b   = {46'd0, trims.sea_factor};
            if (mul_done) begin
               sea_in = (mul_res[63:48] != 16'd0) ? 32'hFFFF_FFFF : mul_res[47:16];
            end
         end
         BK_DONE: begin
            if (can_out) begin
               out_in.temp_centi_c  = temp_ff;
               out_in.station_press = station_ff;
               out_in.sea_press     = sea_ff;
               out_in.div_zero      = dz_ff;
               out_valid_in         = 1'b1;
            end
         end
         default: ;
      endcase
      mul_start = use_mul & ~issued_ff;
      if (use_mul) begin
         issued_in = ~mul_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         issued_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adc_t_ff   <= adc_t_in;
      adc_p_ff   <= adc_p_in;
      ra_ff      <= ra_in;
      v1_ff      <= v1_in;
      v2_ff      <= v2_in;
      sq_ff      <= sq_in;
      p_ff       <= p_in;
      tfine_ff   <= tfine_in;
      station_ff <= station_in;
      sea_ff     <= sea_in;
      temp_ff    <= temp_in;
      dz_ff      <= dz_in;
      out_ff     <= out_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/baro_temp_pressure_compensation_unit.sv =====
// Top level: trim registers, input queue and compensation back end
//
// Takes raw temperature and pressure words and returns temperature in 0.01 C,
// station pressure and sea-level pressure (Q24.8 Pa). Between the input queue
// and the result register a word passes through fourteen wrapping 64-bit
// multiplies on one shared 32x32 multiplier, a bit-serial divider and five
// further steps. When the pressure divisor is zero the divide and the last
// five multiplies are skipped. A two-word input queue and a result register
// let the next word be taken while the previous result waits.
// Write the trims only while the unit is idle.
`default_nettype none
module baro_temp_pressure_compensation_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire bpc_pkg::req_word_type             req_word,
   output logic                                   empty,
   input  wire logic                              pop,
   output bpc_pkg::rsp_word_type                  rsp_word,
   input  wire logic                              csr_write,
   input  wire logic [bpc_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [bpc_pkg::CsrDataWidth-1:0]  csr_data
);
   import bpc_pkg::*;

   trim_type     trims_ff, trims_in;
   logic         in_valid, in_take;
   req_word_type in_word;

   always_comb begin
      trims_in = trims_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TEMP_TRIM:  trims_in.temp_trim  = csr_data[47:0];
            CSR_PRESS_LOW:  trims_in.press_low  = csr_data;
            CSR_PRESS_HIGH: trims_in.press_high = csr_data;
            CSR_PRESS_LAST: trims_in.press_last = csr_data[15:0];
            CSR_SEA_FACTOR: trims_in.sea_factor = csr_data[17:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trims_ff.temp_trim  <= 48'd0;
         trims_ff.press_low  <= 64'd0;
         trims_ff.press_high <= 64'd0;
         trims_ff.press_last <= 16'd0;
         trims_ff.sea_factor <= SeaFactorReset;
      end else begin
         trims_ff <= trims_in;
      end
   end

   bpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .in_valid (in_valid),
      .in_word  (in_word),
      .in_take  (in_take)
   );

   bpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_word  (in_word),
      .in_take  (in_take),
      .trims    (trims_ff),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checks for the compensation unit, bound to the top level
`default_nettype none
module bpc_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  full,
   input wire logic                  empty,
   input wire logic                  pop,
   input wire bpc_pkg::rsp_word_type rsp_word
);
   import bpc_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not clear after reset");

   a_div_zero_pressure: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.div_zero) |->
         (rsp_word.station_press == 32'd0 && rsp_word.sea_press == 32'd0))
      else $error("divide by zero word carries pressure");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result word dropped");

   a_word_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_word))
      else $error("result word changed while waiting");

endmodule

bind baro_temp_pressure_compensation_unit bpc_checker u_bpc_checker (.*);
`default_nettype wire
